/* rtl/ols_pkg.sv */
// ----------------------------------------------------------------------------
// ols_pkg
// Shared constants and types for the linked value store.
// ----------------------------------------------------------------------------
package ols_pkg;

  localparam int MaxEntries = 256;
  localparam int SlotW = $clog2(MaxEntries);
  localparam int PtrW = SlotW + 1;
  localparam logic [PtrW-1:0] NilPtr = PtrW'(MaxEntries);

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [SlotW-1:0] slot_t;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_INS_AFTER  = 3'd1,
    KIND_PUSH_BACK  = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_DEL_KEY    = 3'd4,
    KIND_POP_BACK   = 3'd5,
    KIND_SEARCH     = 3'd6,
    KIND_NONE       = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // One memory port request: read or write of value/link pair.
  typedef struct packed {
    logic        rd;
    logic        wr_val;
    logic        wr_link;
    slot_t       addr;
    logic [31:0] wval;
    ptr_t        wlink;
  } mem_req_t;

  typedef struct packed {
    logic [31:0] rval;
    ptr_t        rlink;
  } mem_rsp_t;

endpackage

/* rtl/ols_node_mem.sv */
// ----------------------------------------------------------------------------
// ols_node_mem
// Node storage: value and link per slot, one port, registered read.
// ----------------------------------------------------------------------------
module ols_node_mem (
  input  logic              clk,
  input  ols_pkg::mem_req_t req,
  output ols_pkg::mem_rsp_t rsp
);
  import ols_pkg::*;

  logic [31:0] val_mem [MaxEntries];
  ptr_t        link_mem [MaxEntries];

  always_ff @(posedge clk) begin
    if (req.wr_val) val_mem[req.addr] <= req.wval;
    if (req.wr_link) link_mem[req.addr] <= req.wlink;
    if (req.rd) begin
      rsp.rval <= val_mem[req.addr];
      rsp.rlink <= link_mem[req.addr];
    end
  end
endmodule

/* rtl/ols_free_stack.sv */
// ----------------------------------------------------------------------------
// ols_free_stack
// Stack of freed slots; pop data registered.
// ----------------------------------------------------------------------------
module ols_free_stack (
  input  logic                 clk,
  input  logic                 push,
  input  ols_pkg::slot_t       push_slot,
  input  logic                 rd,
  input  ols_pkg::slot_t       addr,
  output ols_pkg::slot_t       rdata
);
  import ols_pkg::*;

  slot_t stk [MaxEntries];

  always_ff @(posedge clk) begin
    if (push) stk[addr] <= push_slot;
    if (rd) rdata <= stk[addr];
  end
endmodule

/* rtl/ordered_list_store.sv */
// ----------------------------------------------------------------------------
// ordered_list_store
// Bounded singly linked list of signed 32-bit values in on-chip memory.
// ----------------------------------------------------------------------------
//  channel | signals                        | dir
//  request | in_valid in_stall kind key value | in
//  result  | out_valid out_stall status found entry_count value_sum | out
//
//  One request at a time. Pushes pass S_WAIT, S_ALLOC, S_LINK, S_DONE (only
//  S_WAIT, S_DONE when full), pop front S_WAIT, S_LINK, S_DONE; key walks and
//  pop back read one node per cycle through the single node memory port.
//  Reset empties the list at once; no clearing pass.
//  A result waits in the output register while out_stall is high; the next
//  request is taken in the same cycle the result leaves.
module ordered_list_store (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            kind,
  input  logic signed [31:0]    key,
  input  logic signed [31:0]    value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic                  found,
  output logic [8:0]            entry_count,
  output logic signed [31:0]    value_sum
);
  import ols_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WALK  = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_ALLOC = 7'b0001000,
    S_LINK  = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  kind_t       op;
  logic [31:0] op_key, op_val;
  ptr_t        head, tail, free_top, fresh, count;
  logic [31:0] sum;
  ptr_t        cur, prev;
  ptr_t        new_slot;
  ptr_t        cur_link;
  logic        use_stack;
  logic        hit;
  logic [PtrW:0] steps;

  mem_req_t req;
  mem_rsp_t rsp;
  logic fs_push, fs_rd;
  slot_t fs_addr, fs_rdata, fs_pslot;

  ols_node_mem u_mem (.clk(clk), .req(req), .rsp(rsp));
  ols_free_stack u_fs (.clk(clk), .push(fs_push), .push_slot(fs_pslot),
                       .rd(fs_rd), .addr(fs_addr), .rdata(fs_rdata));

  logic acc;
  assign acc = in_valid && !in_stall;
  assign in_stall = !(state == S_IDLE || (state == S_OUT && !out_stall));

  logic full;
  assign full = (free_top == '0) && (fresh == NilPtr);

  // Walk step: compare data of cur (read last cycle).
  logic walk_stop, walk_hit;
  always_comb begin
    walk_hit = 1'b0;
    walk_stop = 1'b0;
    if (cur == NilPtr || steps >= (PtrW+1)'(MaxEntries)) walk_stop = 1'b1;
    else if (op == KIND_POP_BACK) begin
      if (cur == tail) begin walk_stop = 1'b1; walk_hit = 1'b1; end
    end else if (rsp.rval == op_key) begin
      walk_stop = 1'b1; walk_hit = 1'b1;
    end
  end

  always_comb begin
    req = '0;
    fs_push = 1'b0;
    fs_rd = 1'b0;
    fs_addr = slot_t'(free_top - 1'b1);
    fs_pslot = cur[SlotW-1:0];
    unique case (state)
      S_IDLE, S_OUT: begin
        if (acc) begin
          req.rd = 1'b1;
          req.addr = head[SlotW-1:0];
          fs_rd = 1'b1;
        end
      end
      S_WALK: begin
        if (!walk_stop) begin
          req.rd = 1'b1;
          req.addr = rsp.rlink[SlotW-1:0];
        end
      end
      default: ;
    endcase
    if (state == S_LINK) begin
      unique case (op)
        KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INS_AFTER: begin
          req.wr_val = 1'b1;
          req.wr_link = 1'b1;
          req.addr = new_slot[SlotW-1:0];
          req.wval = op_val;
          req.wlink = (op == KIND_PUSH_FRONT) ? head :
                      (op == KIND_PUSH_BACK) ? NilPtr : cur_link;
        end
        default: begin
          // removal: relink predecessor, push slot
          req.wr_link = (prev != NilPtr);
          req.addr = prev[SlotW-1:0];
          req.wlink = cur_link;
          fs_push = (free_top < PtrW'(MaxEntries));
          fs_addr = free_top[SlotW-1:0];
        end
      endcase
    end else if (state == S_DONE && status == ST_OK && hit) begin
      // second write for inserts after
      if (op == KIND_PUSH_BACK && tail != NilPtr && tail != new_slot) begin
        req.wr_link = 1'b1;
        req.addr = tail[SlotW-1:0];
        req.wlink = new_slot;
      end else if (op == KIND_INS_AFTER) begin
        req.wr_link = 1'b1;
        req.addr = cur[SlotW-1:0];
        req.wlink = new_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= NilPtr;
      tail <= NilPtr;
      free_top <= '0;
      fresh <= '0;
      count <= '0;
      sum <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE, S_OUT: begin
          if (state == S_OUT && !out_stall) out_valid <= 1'b0;
          if (acc) begin
            state <= S_WAIT;
            op <= kind_t'(kind);
            op_key <= key;
            op_val <= value;
            cur <= head;
            prev <= NilPtr;
            steps <= '0;
            hit <= 1'b0;
          end else if (state == S_OUT && !out_stall) state <= S_IDLE;
        end
        S_WAIT: begin
          // head node data now valid
          status <= ST_OK;
          found <= 1'b0;
          use_stack <= (free_top != '0);
          unique case (op)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              if (full) begin status <= ST_FULL; state <= S_DONE; end
              else state <= S_ALLOC;
            end
            KIND_POP_FRONT: begin
              if (head == NilPtr) begin status <= ST_EMPTY; state <= S_DONE; end
              else begin
                cur_link <= rsp.rlink;
                hit <= 1'b1;
                state <= S_LINK;
              end
            end
            KIND_DEL_KEY, KIND_POP_BACK: begin
              if (head == NilPtr || (op == KIND_POP_BACK && tail == NilPtr)) begin
                status <= ST_EMPTY; state <= S_DONE;
              end else state <= S_WALK;
            end
            KIND_INS_AFTER, KIND_SEARCH: state <= S_WALK;
            default: state <= S_DONE;
          endcase
        end
        S_WALK: begin
          if (walk_stop) begin
            cur_link <= rsp.rlink;
            found <= walk_hit && op != KIND_POP_BACK;
            if (!walk_hit) begin
              status <= ST_NOT_FOUND;
              state <= S_DONE;
            end else if (op == KIND_SEARCH) state <= S_DONE;
            else if (op == KIND_INS_AFTER) begin
              if (full) begin status <= ST_FULL; state <= S_DONE; end
              else state <= S_ALLOC;
            end else begin
              hit <= 1'b1;
              state <= S_LINK;
            end
          end else begin
            prev <= cur;
            cur <= rsp.rlink;
            steps <= steps + 1'b1;
          end
        end
        S_ALLOC: begin
          if (use_stack) begin
            new_slot <= {1'b0, fs_rdata};
            free_top <= free_top - 1'b1;
          end else begin
            new_slot <= fresh;
            fresh <= fresh + 1'b1;
          end
          state <= S_LINK;
        end
        S_LINK: begin
          hit <= 1'b1;
          unique case (op)
            KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INS_AFTER: begin
              count <= count + 1'b1;
              sum <= sum + op_val;
              if (op == KIND_PUSH_FRONT) begin
                head <= new_slot;
                if (tail == NilPtr) tail <= new_slot;
              end
              state <= S_DONE;
            end
            default: begin
              if (prev == NilPtr) head <= cur_link;
              if (tail == cur) tail <= prev;
              sum <= sum - rsp.rval;
              if (count != '0) count <= count - 1'b1;
              if (free_top < PtrW'(MaxEntries)) free_top <= free_top + 1'b1;
              hit <= 1'b0;
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (status == ST_OK && hit) begin
            if (op == KIND_PUSH_BACK) begin
              if (tail == NilPtr) head <= new_slot;
              tail <= new_slot;
            end else if (op == KIND_INS_AFTER && tail == cur) tail <= new_slot;
          end
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign entry_count = count;
  assign value_sum = sum;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= PtrW'(MaxEntries)) else $error("count overflow");
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((head == NilPtr) == (tail == NilPtr)))
    else $error("head/tail mismatch");
  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE)) else $error("stray result");
endmodule
